// File: design/narma10_recurrence_assert.svh
// ----------------------------------------------------------------------------
// narma10_recurrence_assert.svh
// Assertion macros shared by the recurrence RTL. Each macro expects clk and
// rst_n in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef NARMA10_RECURRENCE_ASSERT_SVH
`define NARMA10_RECURRENCE_ASSERT_SVH

// Same-cycle implication
`define N10_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define N10_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/narma10_pkg.sv
// ----------------------------------------------------------------------------
// narma10_pkg
// Shared types and constants for the NARMA-10 recurrence block.
// ----------------------------------------------------------------------------
`default_nettype none

package narma10_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int VALUE_W   = 32;
    localparam int COEF_W    = 20;
    localparam int CFG_IDX_W = 3;

    // Default recurrence order
    localparam int ORDER_DEF = 10;

    // Coefficient reset values, signed Q3.16
    localparam logic signed [COEF_W-1:0] COEF_A_RST = 20'sd19661;
    localparam logic signed [COEF_W-1:0] COEF_B_RST = 20'sd3277;
    localparam logic signed [COEF_W-1:0] COEF_C_RST = 20'sd98304;
    localparam logic signed [COEF_W-1:0] COEF_D_RST = 20'sd6554;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;

    // Saturation limits
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // Input word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } item_t;

    // Result word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      overflow;
    } result_t;

endpackage

`default_nettype wire

// File: design/narma10_recurrence.sv
// A full item runs the multiply sequence S_AY to S_ADD before S_DONE; a warm-up
// item (the first ORDER-1 of a sequence) goes straight to S_DONE and shows a zero.
// A new sample is taken only in S_IDLE, after the last one's result is registered;
// six products per item go in turn through the one shared multiplier.
// A sample marked last is absorbed in its acceptance cycle and gives no result.
// Reset (rst_n low, asynchronous) clears all history and restores coefficients.
// ----------------------------------------------------------------------------
// narma10_recurrence
// Streaming NARMA-10 system in fixed point: one signed multiplier and an
// accumulator run under a small sequencer, with shift lines for the history.
// ----------------------------------------------------------------------------
`default_nettype none

module narma10_recurrence #(
    parameter int ORDER = narma10_pkg::ORDER_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [narma10_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [narma10_pkg::COEF_W-1:0]       cfg_data,
    // sample channel
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire narma10_pkg::item_t                   item,
    // result channel
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output narma10_pkg::result_t                      result
);

    import narma10_pkg::*;

    `include "narma10_recurrence_assert.svh"

    // Derived widths
    localparam int CNT_W = $clog2(ORDER);
    localparam int SUM_W = VALUE_W + $clog2(ORDER);
    localparam int HI_W  = SUM_W - 16;
    localparam int X_W   = 36;
    localparam int Y_W   = (HI_W > COEF_W) ? HI_W : COEF_W;
    localparam int P_W   = X_W + Y_W;
    localparam int ACC_W = P_W + 2;

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AY   = 4'd1;
    localparam logic [3:0] S_BY   = 4'd2;
    localparam logic [3:0] S_QH   = 4'd3;
    localparam logic [3:0] S_QL   = 4'd4;
    localparam logic [3:0] S_UU   = 4'd5;
    localparam logic [3:0] S_CU   = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic signed [COEF_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [SAMPLE_W-1:0]       in_hist_reg [ORDER-1];
    logic signed [VALUE_W-1:0] out_hist_reg [ORDER];
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic                      warm_reg, warm_next;
    logic signed [P_W-1:0]     prod_reg, prod_next;
    logic signed [X_W-1:0]     q_reg, q_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    result_t                   result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic signed [X_W-1:0]     x_op;
    logic signed [Y_W-1:0]     y_op;
    logic                      push_in, push_out, hist_clear;
    logic                      sat_ovf;
    logic signed [VALUE_W-1:0] sat_value;
    logic [ACC_W-32:0]         acc_top;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Saturate the accumulator to signed 32 bits
    always_comb
    begin
        acc_top   = acc_reg[ACC_W-1:31];
        sat_ovf   = !((&acc_top) || !(|acc_top));
        if (sat_ovf)
        begin
            sat_value = acc_reg[ACC_W-1] ? VALUE_MIN : VALUE_MAX;
        end
        else
        begin
            sat_value = acc_reg[VALUE_W-1:0];
        end
    end

    // Sequencer, operand select and accumulator
    always_comb
    begin
        state_next        = state_reg;
        sum_next          = sum_reg;
        cnt_next          = cnt_reg;
        sample_next       = sample_reg;
        warm_next         = warm_reg;
        q_next            = q_reg;
        acc_next          = acc_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        push_in           = 1'b0;
        push_out          = 1'b0;
        hist_clear        = 1'b0;
        x_op              = '0;
        y_op              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.last_sample)
                    begin
                        // drop the sample and clear all history
                        hist_clear = 1'b1;
                        cnt_next   = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        sample_next = item.sample;
                        if (cnt_reg < CNT_W'(ORDER - 1))
                        begin
                            warm_next  = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            warm_next  = 1'b0;
                            state_next = S_AY;
                        end
                    end
                end
            end
            S_AY:
            begin
                // a * y
                x_op       = X_W'(out_hist_reg[0]);
                y_op       = Y_W'(coef_a_reg);
                state_next = S_BY;
            end
            S_BY:
            begin
                // start from d plus the linear term; b * y
                acc_next   = ACC_W'(coef_d_reg) + ACC_W'(prod_reg >>> 16);
                x_op       = X_W'(out_hist_reg[0]);
                y_op       = Y_W'(coef_b_reg);
                state_next = S_QH;
            end
            S_QH:
            begin
                // q times the upper part of the window sum
                q_next     = $signed(prod_reg[16 +: X_W]);
                x_op       = $signed(prod_reg[16 +: X_W]);
                y_op       = Y_W'($signed(sum_reg[SUM_W-1:16]));
                state_next = S_QL;
            end
            S_QL:
            begin
                // add q * s_hi; q times the lower 16 bits
                acc_next   = acc_reg + ACC_W'(prod_reg);
                x_op       = q_reg;
                y_op       = Y_W'(sum_reg[15:0]);
                state_next = S_UU;
            end
            S_UU:
            begin
                // add floor(q * s_lo / 2^16); current times lagged sample
                acc_next   = acc_reg + ACC_W'(prod_reg >>> 16);
                x_op       = X_W'(in_hist_reg[ORDER-2]);
                y_op       = Y_W'(sample_reg);
                state_next = S_CU;
            end
            S_CU:
            begin
                // c * (u * lag)
                x_op       = X_W'(prod_reg[31:0]);
                y_op       = Y_W'(coef_c_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg >>> 32);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    push_in           = 1'b1;
                    state_next        = S_IDLE;
                    if (warm_reg)
                    begin
                        result_next.value    = '0;
                        result_next.overflow = 1'b0;
                        cnt_next             = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next.value    = sat_value;
                        result_next.overflow = sat_ovf;
                        push_out             = 1'b1;
                        sum_next             = sum_reg + SUM_W'(sat_value)
                                             - SUM_W'(out_hist_reg[ORDER-1]);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shared multiplier
        prod_next = P_W'(x_op) * P_W'(y_op);
    end

    // Control, coefficient and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            coef_a_reg       <= COEF_A_RST;
            coef_b_reg       <= COEF_B_RST;
            coef_c_reg       <= COEF_C_RST;
            coef_d_reg       <= COEF_D_RST;
            sum_reg          <= '0;
            cnt_reg          <= '0;
            warm_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            cnt_reg          <= cnt_next;
            warm_reg         <= warm_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_COEF_A: coef_a_reg <= $signed(cfg_data);
                    REG_COEF_B: coef_b_reg <= $signed(cfg_data);
                    REG_COEF_C: coef_c_reg <= $signed(cfg_data);
                    REG_COEF_D: coef_d_reg <= $signed(cfg_data);
                    default:    ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        q_reg      <= q_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    // History shift lines: advance on push, clear on reset or a last sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORDER - 1; k++)
            begin
                in_hist_reg[k] <= '0;
            end
            for (int k = 0; k < ORDER; k++)
            begin
                out_hist_reg[k] <= '0;
            end
        end
        else if (hist_clear)
        begin
            for (int k = 0; k < ORDER - 1; k++)
            begin
                in_hist_reg[k] <= '0;
            end
            for (int k = 0; k < ORDER; k++)
            begin
                out_hist_reg[k] <= '0;
            end
        end
        else
        begin
            if (push_in)
            begin
                for (int k = ORDER - 2; k > 0; k--)
                begin
                    in_hist_reg[k] <= in_hist_reg[k-1];
                end
                in_hist_reg[0] <= sample_reg;
            end
            if (push_out)
            begin
                for (int k = ORDER - 1; k > 0; k--)
                begin
                    out_hist_reg[k] <= out_hist_reg[k-1];
                end
                out_hist_reg[0] <= sat_value;
            end
        end
    end

    // Checks
    `N10_ASSERT_NEXT(a_done_delivers,
        (state_reg == S_DONE) && (!result_valid_reg || result_ready),
        result_valid && (state_reg == S_IDLE),
        "finished word not delivered")
    `N10_ASSERT_NEXT(a_full_item_starts,
        item_valid && item_ready && !item.last_sample && (cnt_reg == CNT_W'(ORDER - 1)),
        state_reg == S_AY,
        "full item did not start the multiply sequence")
    `N10_ASSERT_NEXT(a_last_clears,
        item_valid && item_ready && item.last_sample,
        (cnt_reg == '0) && (sum_reg == '0) && (state_reg == S_IDLE),
        "last sample left history or made a word")
    `N10_ASSERT_SAME(a_ovf_saturated,
        result_valid && result.overflow,
        (result.value == VALUE_MAX) || (result.value == VALUE_MIN),
        "overflow flagged on an unsaturated value")

endmodule

`default_nettype wire
